/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and mapping functions
// Status codes, the queued operation word and the byte/code point maps of
// the byte-level BPE byte codec.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBadLead  = 3'd1,
    StTrunc    = 3'd2,
    StBadCont  = 3'd3,
    StUnmapped = 3'd4
  } status_e;

  // One queued operation: one output word, or two when two_words is set.
  typedef struct packed {
    logic       two_words;
    logic [7:0] byte0;
    logic [7:0] byte1;
    status_e    status;
  } op_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] value;
  } map_t;

  // Raw byte to display code point (33..323).
  function automatic logic [8:0] byte_to_cp(input logic [7:0] b);
    logic [8:0] cp;
    if (b <= 8'd32) begin
      cp = 9'd256 + {1'b0, b};
    end else if (b >= 8'd127 && b <= 8'd160) begin
      cp = {1'b0, b} + 9'd162;
    end else if (b == 8'd173) begin
      cp = 9'd323;
    end else begin
      cp = {1'b0, b};
    end
    return cp;
  endfunction

  // Display code point back to raw byte; ok low when unmapped.
  function automatic map_t cp_to_byte(input logic [20:0] cp);
    map_t       m;
    logic [6:0] idx;
    idx     = cp[6:0];
    m.ok    = 1'b0;
    m.value = cp[7:0];
    if (cp < 21'd256) begin
      m.ok = (cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
             (cp >= 21'd174);
    end else if (cp <= 21'd323) begin
      m.ok = 1'b1;
      if (idx < 7'd33) begin
        m.value = {1'b0, idx};
      end else if (idx < 7'd67) begin
        m.value = {1'b0, idx} + 8'd94;
      end else begin
        m.value = 8'd173;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/bbc_ifs.sv */
// ----------------------------------------------------------------------------
// bbc interfaces: input, output and configuration channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;
  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic [2:0] status;
  modport source (output valid, out_byte, last, status, input ready);
  modport sink   (input valid, out_byte, last, status, output ready);
endinterface

interface bbc_cfg_if;
  logic valid;
  logic ready;
  logic direction;
  modport source (output valid, direction, input ready);
  modport sink   (input valid, direction, output ready);
endinterface

/* rtl/byte_level_bpe_byte_codec.sv */
// ----------------------------------------------------------------------------
// byte_level_bpe_byte_codec: byte-level BPE byte/display transcoder
// Top level joining front end, operation queue and output sequencer.
// ----------------------------------------------------------------------------
// In encode mode (direction 0) each input word yields one output word for
// code points below 128 and two words otherwise; in decode mode (direction
// 1) it takes one input word per cycle while the queue has room and yields
// at most one output word each. An input word is taken whenever the
// operation queue has room, even while an output word waits. An accepted
// word is registered in the queue and then in the sequencer's output
// register before output valid rises. Write the direction only while the
// block is idle; every write also resets the decoder.
module byte_level_bpe_byte_codec #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bbc_in_if.sink     byte_in_i,
  bbc_out_if.source  byte_out_o,
  bbc_cfg_if.sink    cfg_i
);

  logic             push, full, pop;
  bbc_pkg::op_t     op;
  bbc_pkg::q_head_t head;

  // classify input words and run the UTF-8 gatherer
  bbc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (byte_in_i),
    .cfg_ch   (cfg_i),
    .q_full_i (full),
    .push_o   (push),
    .op_o     (op)
  );

  // hold pending operations while the output side stalls
  bbc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  // advance through each operation one output word per cycle while the output side is ready
  bbc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (byte_out_o)
  );

endmodule

/* rtl/bbc_front.sv */
// ----------------------------------------------------------------------------
// bbc_front: accept and classify input bytes
// Maps raw bytes in encode mode and runs the UTF-8 gatherer in decode mode,
// pushing at most one operation per accepted word into the queue.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbc_in_if.sink        in_ch,
  bbc_cfg_if.sink       cfg_ch,
  input  logic          q_full_i,
  output logic          push_o,
  output bbc_pkg::op_t  op_o
);

  logic        dir_q;
  logic [1:0]  pend_q, pend_d;
  logic [20:0] acc_q, acc_d;
  logic        accept;
  logic [7:0]  b;
  logic [8:0]  enc_cp;
  logic [20:0] acc_next;
  bbc_pkg::map_t m;

  assign in_ch.ready  = !q_full_i;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign b            = in_ch.in_byte;
  assign enc_cp       = bbc_pkg::byte_to_cp(b);
  assign acc_next     = (pend_q == 2'd0) ? {13'd0, b} : {acc_q[14:0], b[5:0]};
  assign m            = bbc_pkg::cp_to_byte(acc_next);

  always_comb begin
    pend_d          = pend_q;
    acc_d           = acc_q;
    push_o          = 1'b0;
    op_o.two_words  = 1'b0;
    op_o.byte0      = 8'd0;
    op_o.byte1      = 8'd0;
    op_o.status     = bbc_pkg::StOk;
    if (accept) begin
      if (!dir_q) begin
        push_o = 1'b1;
        if (enc_cp < 9'd128) begin
          op_o.byte0 = enc_cp[7:0];
        end else begin
          op_o.two_words = 1'b1;
          op_o.byte0     = 8'hC0 | {5'd0, enc_cp[8:6]};
          op_o.byte1     = 8'h80 | {2'd0, enc_cp[5:0]};
        end
      end else if (pend_q == 2'd0) begin
        if (b[7] == 1'b0) begin
          // single-byte code point: finish at once
          push_o = 1'b1;
          if (m.ok) op_o.byte0 = m.value;
          else      op_o.status = bbc_pkg::StUnmapped;
          acc_d = 21'd0;
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
          if (b[5] == 1'b0) begin
            pend_d = 2'd1;
            acc_d  = {16'd0, b[4:0]};
          end else if (b[4] == 1'b0) begin
            pend_d = 2'd2;
            acc_d  = {17'd0, b[3:0]};
          end else begin
            pend_d = 2'd3;
            acc_d  = {18'd0, b[2:0]};
          end
          if (in_ch.end_of_string) begin
            push_o      = 1'b1;
            op_o.status = bbc_pkg::StTrunc;
            pend_d      = 2'd0;
            acc_d       = 21'd0;
          end
        end else begin
          push_o      = 1'b1;
          op_o.status = bbc_pkg::StBadLead;
          acc_d       = 21'd0;
        end
      end else if (b[7:6] != 2'b10) begin
        // drop the offending byte and reset the gatherer
        push_o      = 1'b1;
        op_o.status = bbc_pkg::StBadCont;
        pend_d      = 2'd0;
        acc_d       = 21'd0;
      end else begin
        pend_d = pend_q - 2'd1;
        acc_d  = acc_next;
        if (pend_q == 2'd1) begin
          push_o = 1'b1;
          if (m.ok) op_o.byte0 = m.value;
          else      op_o.status = bbc_pkg::StUnmapped;
          acc_d = 21'd0;
        end else if (in_ch.end_of_string) begin
          push_o      = 1'b1;
          op_o.status = bbc_pkg::StTrunc;
          pend_d      = 2'd0;
          acc_d       = 21'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      pend_q <= 2'd0;
      acc_q  <= 21'd0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      dir_q  <= cfg_ch.direction;
      pend_q <= 2'd0;
      acc_q  <= 21'd0;
    end else begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

  a_eos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_ch.end_of_string && !(cfg_ch.valid && cfg_ch.ready) |=> pend_q == 2'd0)
    else $error("decoder not idle after end of string");

endmodule

/* rtl/bbc_queue.sv */
// ----------------------------------------------------------------------------
// bbc_queue: short operation queue
// Decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
module bbc_queue #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bbc_pkg::op_t      op_i,
  output logic              full_o,
  input  logic              pop_i,
  output bbc_pkg::q_head_t  head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bbc_pkg::op_t    mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("operation pushed into a full queue");

endmodule

/* rtl/bbc_back.sv */
// ----------------------------------------------------------------------------
// bbc_back: output sequencer
// Pops operations and drives one output word per cycle from a register while ready is high.
// ----------------------------------------------------------------------------
module bbc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbc_pkg::q_head_t  head_i,
  output logic              pop_o,
  bbc_out_if.source         out_ch
);

  bbc_pkg::op_t cur_q;
  logic         busy_q, phase_q;
  logic         fire, done, load;

  assign out_ch.valid    = busy_q;
  assign out_ch.out_byte = phase_q ? cur_q.byte1 : cur_q.byte0;
  assign out_ch.last     = !cur_q.two_words || phase_q;
  assign out_ch.status   = cur_q.status;

  assign fire  = out_ch.valid && out_ch.ready;
  assign done  = fire && out_ch.last;
  assign load  = !busy_q || done;
  assign pop_o = load && head_i.valid;

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= head_i.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      busy_q  <= head_i.valid;
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= 1'b1;
    end
  end

  a_second_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !out_ch.last |=> out_ch.valid && phase_q)
    else $error("second word of a pair lost");

endmodule
